[rtl/core/spq_pkg.sv]
// spq_pkg: shared types, codes and sizes for the sorted priority queue
// used by every file under rtl/core; depends on nothing
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // request kinds
    localparam logic [1:0] REQ_INSERT    = 2'd0;
    localparam logic [1:0] REQ_POP       = 2'd1;
    localparam logic [1:0] REQ_REMOVE_EQ = 2'd2;
    localparam logic [1:0] REQ_POP_GE    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOMATCH  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] entry_value;
        logic [7:0]         priority_key;
    } spq_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] removed_value;
        logic [7:0]         removed_priority;
        logic [4:0]         entry_count;
    } spq_rsp_t;

    typedef struct packed {
        logic signed [31:0]     val;
        logic [PRIO_BITS-1:0]   pri;
    } entry_t;

    // per-cell compare results against the request key
    typedef struct packed {
        logic gt_key;
        logic lt_key;
        logic eq_key;
    } cell_flags_t;

    typedef enum logic [1:0] {
        ACT_HOLD       = 2'd0,
        ACT_LOAD       = 2'd1,
        ACT_TAKE_LEFT  = 2'd2,
        ACT_TAKE_RIGHT = 2'd3
    } cell_action_t;

endpackage

[rtl/core/spq_cell.sv]
// spq_cell: one slot of the sorted chain, holds an entry and compares it to the key
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
(
    input  logic                 clk,
    input  logic                 occupied,
    input  logic [PRIO_BITS-1:0] key,
    input  entry_t               new_entry,
    input  entry_t               left_entry,
    input  entry_t               right_entry,
    input  cell_action_t         action,
    output entry_t               entry,
    output cell_flags_t          flags
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (action)
            ACT_LOAD:       entry_next = new_entry;
            ACT_TAKE_LEFT:  entry_next = left_entry;
            ACT_TAKE_RIGHT: entry_next = right_entry;
            default:        entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry        = entry_reg;
    assign flags.gt_key = occupied && (entry_reg.pri > key);
    assign flags.lt_key = occupied && (entry_reg.pri < key);
    assign flags.eq_key = occupied && (entry_reg.pri == key);

endmodule

[rtl/core/spq_ctrl.sv]
// spq_ctrl: turns the cell compare flags into per-cell shift commands and the result
// depends on spq_pkg
module spq_ctrl
    import spq_pkg::*;
(
    input  logic                           start_ok,
    input  logic [1:0]                     kind,
    input  logic [CNT_W-1:0]               count,
    input  cell_flags_t [DEPTH-1:0]        flags,
    input  entry_t [DEPTH-1:0]             entries,
    output cell_action_t [DEPTH-1:0]       actions,
    output logic [CNT_W-1:0]               count_next,
    output logic [2:0]                     status,
    output entry_t                         removed
);

    logic             is_empty;
    logic             is_full;
    logic             ins_head;
    logic             any_hit;
    logic             do_insert;
    logic             do_remove;
    logic [DEPTH-1:0] ins_after;
    logic [DEPTH-1:0] rm_after;
    logic [DEPTH-1:0] rm_first;
    logic [DEPTH-1:0] eq_vec;

    assign is_empty = (count == '0);
    assign is_full  = (count == CNT_W'(DEPTH));
    // the list stays sorted, so "at or after the slot" is a local test in each cell
    assign ins_head = is_empty || flags[0].lt_key;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            eq_vec[i] = flags[i].eq_key;
        end
    end

    assign any_hit = |eq_vec;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                ins_after[i] = ins_head;
            end
            else
            begin
                ins_after[i] = ins_head || !flags[i].gt_key;
            end
            if (kind == REQ_REMOVE_EQ)
            begin
                rm_after[i] = any_hit && !flags[i].gt_key;
            end
            else
            begin
                rm_after[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                rm_first[i] = rm_after[i];
            end
            else
            begin
                rm_first[i] = rm_after[i] && !rm_after[i-1];
            end
        end
    end

    always_comb
    begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (rm_first[i])
            begin
                removed = removed | entries[i];
            end
        end
    end

    always_comb
    begin
        status    = ST_INSERTED;
        do_insert = 1'b0;
        do_remove = 1'b0;
        if (kind == REQ_INSERT)
        begin
            if (is_full)
            begin
                status = ST_FULL;
            end
            else
            begin
                status    = ST_INSERTED;
                do_insert = 1'b1;
            end
        end
        else if (is_empty)
        begin
            status = ST_EMPTY;
        end
        else if (kind == REQ_POP)
        begin
            status    = ST_REMOVED;
            do_remove = 1'b1;
        end
        else if (kind == REQ_REMOVE_EQ)
        begin
            status    = any_hit ? ST_REMOVED : ST_NOMATCH;
            do_remove = any_hit;
        end
        else
        begin
            status    = flags[0].lt_key ? ST_NOMATCH : ST_REMOVED;
            do_remove = !flags[0].lt_key;
        end
    end

    always_comb
    begin
        count_next = count;
        if (start_ok && do_insert)
        begin
            count_next = count + CNT_W'(1);
        end
        else if (start_ok && do_remove)
        begin
            count_next = count - CNT_W'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            actions[i] = ACT_HOLD;
            if (start_ok && do_insert && ins_after[i])
            begin
                if (i == 0)
                begin
                    actions[i] = ACT_LOAD;
                end
                else if (ins_after[i-1])
                begin
                    actions[i] = ACT_TAKE_LEFT;
                end
                else
                begin
                    actions[i] = ACT_LOAD;
                end
            end
            else if (start_ok && do_remove && rm_after[i])
            begin
                actions[i] = ACT_TAKE_RIGHT;
            end
        end
    end

endmodule

[rtl/core/sorted_priority_queue.sv]
// sorted_priority_queue: top level, a chain of spq_cell slots steered by spq_ctrl
// depends on spq_pkg, spq_cell, spq_ctrl
//
// usage
//   a transaction enters when start is high and busy is low; req carries the request
//   kind, the value to store and the priority key or threshold
//   every transaction gives exactly one result on rsp, shown for one cycle with done
//   high; the result is registered at the accepting edge
//   all slots compare against the key in parallel and shift toward or away from the
//   head in the same edge, so a new transaction may follow in every cycle; busy
//   stays low
//   the entry count after the transaction is reported with every result
//   reset clears the entry count and the result strobe; slot contents are not
//   cleared, only slots below the count are ever read
//   the receiver cannot stall: a result is taken in the cycle it is shown
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  spq_req_t req,
    output logic     busy,
    output logic     done,
    output spq_rsp_t rsp
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    spq_rsp_t                 rsp_reg;
    spq_rsp_t                 rsp_next;
    logic                     start_ok;
    logic [PRIO_BITS-1:0]     key;
    entry_t                   new_entry;
    entry_t                   removed;
    logic [2:0]               status;
    entry_t [DEPTH-1:0]       entries;
    cell_flags_t [DEPTH-1:0]  flags;
    cell_action_t [DEPTH-1:0] actions;

    assign busy     = 1'b0;
    assign start_ok = start && !busy;
    assign key      = PRIO_BITS'(req.priority_key);

    assign new_entry.val = req.entry_value;
    assign new_entry.pri = key;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   occupied;

            if (g == 0)
            begin : g_head
                assign left_entry = '0;
            end
            else
            begin : g_mid
                assign left_entry = entries[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_body
                assign right_entry = entries[g+1];
            end

            assign occupied = (CNT_W'(g) < count_reg);

            spq_cell u_cell (
                .clk         (clk),
                .occupied    (occupied),
                .key         (key),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .action      (actions[g]),
                .entry       (entries[g]),
                .flags       (flags[g])
            );
        end
    endgenerate

    spq_ctrl u_ctrl (
        .start_ok   (start_ok),
        .kind       (req.req_type),
        .count      (count_reg),
        .flags      (flags),
        .entries    (entries),
        .actions    (actions),
        .count_next (count_next),
        .status     (status),
        .removed    (removed)
    );

    always_comb
    begin
        rsp_next.status           = status;
        rsp_next.removed_value    = (status == ST_REMOVED) ? removed.val : '0;
        rsp_next.removed_priority = (status == ST_REMOVED) ? 8'(removed.pri) : '0;
        rsp_next.entry_count      = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_ok)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[rtl/core/spq_checker.sv]
// spq_checker: port-level assertions for the sorted priority queue, bound to the top
// depends on spq_pkg and sorted_priority_queue
module spq_port_checks
    import spq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input spq_rsp_t rsp
);

    // every accepted transaction gives a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted transaction gave no result");

    // no result without an accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a transaction");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_REMOVED) |->
            (rsp.removed_value == '0 && rsp.removed_priority == '0))
        else $error("removed fields not zero");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (rsp.entry_count == 5'(DEPTH)))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_EMPTY || rsp.status == ST_INSERTED)) |->
            (rsp.status == ST_EMPTY ? rsp.entry_count == '0 : rsp.entry_count != '0))
        else $error("entry count does not match status");

endmodule

bind sorted_priority_queue spq_port_checks u_spq_checker (.*);
